// ----- design/length_prefixed_message_fifo_core_assert.svh -----
// Assertion macros used by the message queue datapath.
`ifndef LENGTH_PREFIXED_MESSAGE_FIFO_CORE_ASSERT_SVH
`define LENGTH_PREFIXED_MESSAGE_FIFO_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPMF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lpmf assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LPMF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lpmf assertion failed");

`endif

// ----- design/lpmf_pkg.sv -----
package lpmf_pkg;

   localparam int RING_BYTES = 1024;
   localparam int PTR_W      = $clog2(RING_BYTES);
   localparam int SIZE_W     = 11;
   localparam int LEN_W      = 16;
   localparam int BYTE_W     = 8;
   localparam int ACT_W      = 2;
   localparam int STAT_W     = 3;
   localparam int APB_AW     = 3;
   localparam int APB_DW     = 32;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(RING_BYTES);
   localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(3);

   // Word index of the buffer_size register.
   localparam logic ADDR_BUFFER_SIZE = 1'b0;

   localparam logic [ACT_W-1:0] ACT_START = 2'd0;
   localparam logic [ACT_W-1:0] ACT_DATA  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

   localparam logic [STAT_W-1:0] STS_OK         = 3'd0;
   localparam logic [STAT_W-1:0] STS_BAD_LEN    = 3'd1;
   localparam logic [STAT_W-1:0] STS_EMPTY      = 3'd2;
   localparam logic [STAT_W-1:0] STS_NO_WRITE   = 3'd3;
   localparam logic [STAT_W-1:0] STS_WRITE_OPEN = 3'd4;

   typedef struct packed {
      logic              latch;
      logic              set_status;
      logic [STAT_W-1:0] status;
      logic              wr_hdr_hi;
      logic              wr_hdr_lo;
      logic              wr_data;
      logic              rd_issue;
      logic              rd_hi;
      logic              rd_hdr;
      logic              rd_fin;
   } lpmf_cmd_type;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic             wr_open;
      logic             rd_open;
      logic             empty;
      logic             len_bad;
      logic             hdr_zero;
   } lpmf_stat_type;

endpackage

// ----- design/lpmf_ram.sv -----
module lpmf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- design/lpmf_ctrl.sv -----
module lpmf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   output logic                   rsp_strobe,
   input  lpmf_pkg::lpmf_stat_type stat,
   output lpmf_pkg::lpmf_cmd_type  cmd
);

   import lpmf_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_EXEC   = 7'b0000010,
      S_WR_LO  = 7'b0000100,
      S_RD_LO  = 7'b0001000,
      S_RD_HDR = 7'b0010000,
      S_RD_FIN = 7'b0100000,
      S_RESP   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.status = STS_OK;
      case (state_ff)
         S_IDLE, S_RESP: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = S_EXEC;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_EXEC: begin
            state_in = S_RESP;
            case (stat.action)
               ACT_START: begin
                  if (stat.wr_open) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = STS_WRITE_OPEN;
                  end else if (stat.len_bad) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = STS_BAD_LEN;
                  end else begin
                     cmd.wr_hdr_hi = 1'b1;
                     state_in      = S_WR_LO;
                  end
               end
               ACT_DATA: begin
                  if (!stat.wr_open) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = STS_NO_WRITE;
                  end else begin
                     cmd.wr_data = 1'b1;
                  end
               end
               ACT_READ: begin
                  if (stat.rd_open) begin
                     cmd.rd_issue = 1'b1;
                     state_in     = S_RD_FIN;
                  end else if (stat.empty) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = STS_EMPTY;
                  end else begin
                     cmd.rd_issue = 1'b1;
                     state_in     = S_RD_LO;
                  end
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_WR_LO: begin
            cmd.wr_hdr_lo = 1'b1;
            state_in      = S_RESP;
         end
         S_RD_LO: begin
            cmd.rd_issue = 1'b1;
            cmd.rd_hi    = 1'b1;
            state_in     = S_RD_HDR;
         end
         S_RD_HDR: begin
            cmd.rd_hdr = 1'b1;
            if (stat.hdr_zero) begin
               cmd.set_status = 1'b1;
               cmd.status     = STS_EMPTY;
               state_in       = S_RESP;
            end else begin
               cmd.rd_issue = 1'b1;
               state_in     = S_RD_FIN;
            end
         end
         S_RD_FIN: begin
            cmd.rd_fin = 1'b1;
            state_in   = S_RESP;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // The next item is taken while the previous result is on the ports.
   assign busy       = (state_ff != S_IDLE) && (state_ff != S_RESP);
   assign rsp_strobe = (state_ff == S_RESP);

endmodule

// ----- design/lpmf_dp.sv -----
module lpmf_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  lpmf_pkg::lpmf_cmd_type         cmd,
   output lpmf_pkg::lpmf_stat_type        stat,
   input  logic [lpmf_pkg::ACT_W-1:0]     req_action,
   input  logic [lpmf_pkg::LEN_W-1:0]     req_message_length,
   input  logic [lpmf_pkg::BYTE_W-1:0]    req_data_in,
   input  logic                           cfg_we,
   input  logic [lpmf_pkg::SIZE_W-1:0]    cfg_data,
   output logic [lpmf_pkg::SIZE_W-1:0]    buffer_size,
   output logic [lpmf_pkg::STAT_W-1:0]    rsp_status,
   output logic [lpmf_pkg::BYTE_W-1:0]    rsp_data_out,
   output logic                           rsp_last_byte,
   output logic [lpmf_pkg::LEN_W-1:0]     rsp_read_length,
   output logic                           rsp_data_available,
   output logic [lpmf_pkg::SIZE_W-1:0]    rsp_free_bytes
);

   import lpmf_pkg::*;

   `include "length_prefixed_message_fifo_core_assert.svh"

   logic [SIZE_W-1:0] bsize_ff, bsize_in;
   logic [PTR_W-1:0]  wc_ff, wc_in;
   logic [PTR_W-1:0]  cp_ff, cp_in;
   logic [PTR_W-1:0]  rp_ff, rp_in;
   logic [SIZE_W-1:0] free_ff, free_in;
   logic [LEN_W-1:0]  wrem_ff, wrem_in;
   logic [LEN_W-1:0]  rrem_ff, rrem_in;
   logic [LEN_W-1:0]  crl_ff, crl_in;

   logic [ACT_W-1:0]  act_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [BYTE_W-1:0] din_ff;
   logic [BYTE_W-1:0] hi_ff;
   logic [STAT_W-1:0] status_ff, status_in;
   logic [BYTE_W-1:0] dout_ff, dout_in;
   logic              last_ff, last_in;

   logic              ram_en;
   logic              ram_we;
   logic [PTR_W-1:0]  ram_addr;
   logic [BYTE_W-1:0] ram_wdata;
   logic [BYTE_W-1:0] ram_rdata;

   logic [PTR_W-1:0]  wc_next;
   logic [PTR_W-1:0]  rp_next;
   logic [LEN_W-1:0]  hdr;
   logic [LEN_W:0]    len_plus3;
   logic [SIZE_W-1:0] cfg_size;

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p,
                                                  input logic [SIZE_W-1:0] size);
      logic [SIZE_W-1:0] n;
      begin
         n = SIZE_W'(p) + SIZE_W'(1);
         ring_next = (n >= size) ? '0 : n[PTR_W-1:0];
      end
   endfunction

   assign wc_next   = ring_next(wc_ff, bsize_ff);
   assign rp_next   = ring_next(rp_ff, bsize_ff);
   assign hdr       = {hi_ff, ram_rdata};
   assign len_plus3 = (LEN_W+1)'(len_ff) + (LEN_W+1)'(3);
   assign cfg_size  = (cfg_data > SIZE_RESET) ? SIZE_RESET : cfg_data;

   assign stat.action   = act_ff;
   assign stat.wr_open  = (wrem_ff != '0);
   assign stat.rd_open  = (rrem_ff != '0);
   assign stat.empty    = (rp_ff == cp_ff);
   assign stat.len_bad  = (len_ff == '0) || (len_plus3 > (LEN_W+1)'(free_ff));
   assign stat.hdr_zero = (hdr == '0);

   // Single ring port: writes go to the write cursor, reads to the read pointer.
   assign ram_we   = cmd.wr_hdr_hi | cmd.wr_hdr_lo | cmd.wr_data;
   assign ram_en   = ram_we | cmd.rd_issue;
   assign ram_addr = ram_we ? wc_ff : rp_ff;

   always_comb begin
      if (cmd.wr_hdr_hi) begin
         ram_wdata = len_ff[LEN_W-1:BYTE_W];
      end else if (cmd.wr_hdr_lo) begin
         ram_wdata = len_ff[BYTE_W-1:0];
      end else begin
         ram_wdata = din_ff;
      end
   end

   lpmf_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (RING_BYTES)
   ) u_ring (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   always_comb begin
      bsize_in  = bsize_ff;
      wc_in     = wc_ff;
      cp_in     = cp_ff;
      rp_in     = rp_ff;
      free_in   = free_ff;
      wrem_in   = wrem_ff;
      rrem_in   = rrem_ff;
      crl_in    = crl_ff;
      status_in = status_ff;
      dout_in   = dout_ff;
      last_in   = last_ff;

      if (cmd.latch) begin
         status_in = STS_OK;
         dout_in   = '0;
         last_in   = 1'b0;
      end
      if (cmd.set_status) begin
         status_in = cmd.status;
      end
      if (cmd.wr_hdr_hi) begin
         free_in = free_ff - (len_ff[SIZE_W-1:0] + SIZE_W'(2));
         wrem_in = len_ff;
      end
      if (ram_we) begin
         wc_in = wc_next;
      end
      if (cmd.wr_data) begin
         wrem_in = wrem_ff - LEN_W'(1);
         if (wrem_ff == LEN_W'(1)) begin
            cp_in = wc_next;
         end
      end
      if (cmd.rd_issue) begin
         rp_in = rp_next;
      end
      if (cmd.rd_hdr) begin
         rrem_in = hdr;
         crl_in  = hdr;
         if (hdr == '0) begin
            free_in = free_ff + SIZE_W'(2);
         end
      end
      if (cmd.rd_fin) begin
         dout_in = ram_rdata;
         rrem_in = rrem_ff - LEN_W'(1);
         if (rrem_ff == LEN_W'(1)) begin
            last_in = 1'b1;
            free_in = free_ff + crl_ff[SIZE_W-1:0] + SIZE_W'(2);
         end
      end

      // A size write below the minimum is ignored and leaves the queue alone.
      if (cfg_we && (cfg_data >= SIZE_MIN)) begin
         bsize_in = cfg_size;
         wc_in    = '0;
         cp_in    = '0;
         rp_in    = '0;
         free_in  = cfg_size;
         wrem_in  = '0;
         rrem_in  = '0;
         crl_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bsize_ff <= SIZE_RESET;
         wc_ff    <= '0;
         cp_ff    <= '0;
         rp_ff    <= '0;
         free_ff  <= SIZE_RESET;
         wrem_ff  <= '0;
         rrem_ff  <= '0;
         crl_ff   <= '0;
      end else begin
         bsize_ff <= bsize_in;
         wc_ff    <= wc_in;
         cp_ff    <= cp_in;
         rp_ff    <= rp_in;
         free_ff  <= free_in;
         wrem_ff  <= wrem_in;
         rrem_ff  <= rrem_in;
         crl_ff   <= crl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         act_ff <= req_action;
         len_ff <= req_message_length;
         din_ff <= req_data_in;
      end
      if (cmd.rd_hi) begin
         hi_ff <= ram_rdata;
      end
      status_ff <= status_in;
      dout_ff   <= dout_in;
      last_ff   <= last_in;
   end

   assign buffer_size        = bsize_ff;
   assign rsp_status         = status_ff;
   assign rsp_data_out       = dout_ff;
   assign rsp_last_byte      = last_ff;
   assign rsp_read_length    = crl_ff;
   assign rsp_data_available = (rrem_ff != '0) || (rp_ff != cp_ff);
   assign rsp_free_bytes     = free_ff;

   `LPMF_ASSERT_SAME(a_free_within_size, clock, reset, 1'b1, free_ff <= bsize_ff)
   `LPMF_ASSERT_SAME(a_ptrs_within_size, clock, reset, 1'b1,
      (SIZE_W'(rp_ff) < bsize_ff) && (SIZE_W'(wc_ff) < bsize_ff))
   `LPMF_ASSERT_SAME(a_commit_closes_write, clock, reset, cp_ff != $past(cp_ff),
      wrem_ff == '0)
   `LPMF_ASSERT_NEXT(a_last_releases_read, clock, reset, cmd.rd_fin && (rrem_ff == LEN_W'(1)),
      last_ff && (rrem_ff == '0))

endmodule

// ----- design/length_prefixed_message_fifo_core.sv -----
// From S_EXEC to the result strobe in S_RESP: directly for a data byte, a rejected item or
// an empty read; via S_WR_LO for a message start; via S_RD_FIN for a read inside a message;
// via S_RD_LO, S_RD_HDR and S_RD_FIN for the first read of a message, which fetches both
// header bytes and a data byte from the one-port ring. A new item is accepted in the cycle
// its predecessor's result is shown. Results cannot be stalled. Synchronous reset empties the
// queue, sets buffer_size to 1024 and leaves the ring contents, which need no clearing pass.
module length_prefixed_message_fifo_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [lpmf_pkg::ACT_W-1:0]     req_action,
   input  logic [lpmf_pkg::LEN_W-1:0]     req_message_length,
   input  logic [lpmf_pkg::BYTE_W-1:0]    req_data_in,
   output logic                           rsp_strobe,
   output logic [lpmf_pkg::STAT_W-1:0]    rsp_status,
   output logic [lpmf_pkg::BYTE_W-1:0]    rsp_data_out,
   output logic                           rsp_last_byte,
   output logic [lpmf_pkg::LEN_W-1:0]     rsp_read_length,
   output logic                           rsp_data_available,
   output logic [lpmf_pkg::SIZE_W-1:0]    rsp_free_bytes,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [lpmf_pkg::APB_AW-1:0]    paddr,
   input  logic [lpmf_pkg::APB_DW-1:0]    pwdata,
   output logic [lpmf_pkg::APB_DW-1:0]    prdata,
   output logic                           pready
);

   import lpmf_pkg::*;

   lpmf_cmd_type      cmd;
   lpmf_stat_type     stat;
   logic              cfg_we;
   logic [SIZE_W-1:0] buffer_size;
   logic              reg_hit;

   assign pready  = 1'b1;
   assign reg_hit = (paddr[2] == ADDR_BUFFER_SIZE);
   assign cfg_we  = psel && penable && pwrite && pready && reg_hit;
   assign prdata  = reg_hit ? APB_DW'(buffer_size) : '0;

   lpmf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .stat       (stat),
      .cmd        (cmd)
   );

   lpmf_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_action         (req_action),
      .req_message_length (req_message_length),
      .req_data_in        (req_data_in),
      .cfg_we             (cfg_we),
      .cfg_data           (pwdata[SIZE_W-1:0]),
      .buffer_size        (buffer_size),
      .rsp_status         (rsp_status),
      .rsp_data_out       (rsp_data_out),
      .rsp_last_byte      (rsp_last_byte),
      .rsp_read_length    (rsp_read_length),
      .rsp_data_available (rsp_data_available),
      .rsp_free_bytes     (rsp_free_bytes)
   );

endmodule

// ----- tb/length_prefixed_message_fifo_core_checker.sv -----
`timescale 1ns / 100ps

module length_prefixed_message_fifo_core_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic [lpmf_pkg::ACT_W-1:0]    req_action,
   input  logic [lpmf_pkg::LEN_W-1:0]    req_message_length,
   input  logic [lpmf_pkg::BYTE_W-1:0]   req_data_in,
   input  logic                          rsp_strobe,
   input  logic [lpmf_pkg::STAT_W-1:0]   rsp_status,
   input  logic [lpmf_pkg::BYTE_W-1:0]   rsp_data_out,
   input  logic                          rsp_last_byte,
   input  logic [lpmf_pkg::LEN_W-1:0]    rsp_read_length,
   input  logic                          rsp_data_available,
   input  logic [lpmf_pkg::SIZE_W-1:0]   rsp_free_bytes,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [lpmf_pkg::APB_AW-1:0]   paddr,
   input  logic [lpmf_pkg::APB_DW-1:0]   pwdata,
   input  logic [lpmf_pkg::APB_DW-1:0]   prdata,
   input  logic                          pready,
   output int                            fail_count,
   output int                            replies_pending,
   output int                            results_checked,
   output int                            messages_drained
);

   import lpmf_pkg::*;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [BYTE_W-1:0] data_out;
      logic              last_byte;
      logic [LEN_W-1:0]  read_length;
      logic              data_available;
      logic [SIZE_W-1:0] free_bytes;
   } queue_reply_type;

   // Shadow copy of the message queue.
   logic [BYTE_W-1:0] ring_copy [RING_BYTES];
   int unsigned       ring_size;
   int unsigned       wr_ptr;
   int unsigned       commit_ptr;
   int unsigned       rd_ptr;
   int unsigned       free_left;
   int unsigned       wr_left;
   int unsigned       rd_left;
   int unsigned       rd_len;

   queue_reply_type replies_due [$];
   queue_reply_type want;
   int              mismatches = 0;
   int              checked = 0;
   int              drained = 0;
   int              pending = 0;

   assign fail_count       = mismatches;
   assign replies_pending  = pending;
   assign results_checked  = checked;
   assign messages_drained = drained;

   function automatic int unsigned ring_advance(int unsigned p);
      return (p + 1 >= ring_size) ? 0 : p + 1;
   endfunction

   function automatic void empty_queue();
      wr_ptr     = 0;
      commit_ptr = 0;
      rd_ptr     = 0;
      free_left  = ring_size;
      wr_left    = 0;
      rd_left    = 0;
      rd_len     = 0;
   endfunction

   // Values below the minimum are dropped without touching the queue.
   function automatic void apply_size_write(logic [APB_DW-1:0] value);
      logic [SIZE_W-1:0] sz;
      sz = value[SIZE_W-1:0];
      if (sz < SIZE_MIN)
         return;
      if (sz > RING_BYTES)
         sz = SIZE_RESET;
      ring_size = sz;
      empty_queue();
   endfunction

   function automatic queue_reply_type apply_item(logic [ACT_W-1:0] act,
                                                  logic [LEN_W-1:0] len,
                                                  logic [BYTE_W-1:0] din);
      queue_reply_type r;
      int unsigned     hdr;
      r = '0;
      r.status = STS_OK;
      case (act)
         ACT_START: begin
            if (wr_left != 0) begin
               r.status = STS_WRITE_OPEN;
            end else if (len == 0 || int'(len) + 3 > free_left) begin
               r.status = STS_BAD_LEN;
            end else begin
               free_left -= int'(len) + 2;
               ring_copy[wr_ptr] = len[15:8];
               wr_ptr = ring_advance(wr_ptr);
               ring_copy[wr_ptr] = len[7:0];
               wr_ptr = ring_advance(wr_ptr);
               wr_left = len;
            end
         end
         ACT_DATA: begin
            if (wr_left == 0) begin
               r.status = STS_NO_WRITE;
            end else begin
               ring_copy[wr_ptr] = din;
               wr_ptr = ring_advance(wr_ptr);
               wr_left--;
               if (wr_left == 0)
                  commit_ptr = wr_ptr;
            end
         end
         ACT_READ: begin
            // The first read of a message pulls in its two header bytes.
            if (rd_left == 0) begin
               if (rd_ptr == commit_ptr) begin
                  r.status = STS_EMPTY;
               end else begin
                  hdr = {ring_copy[rd_ptr], 8'h00};
                  rd_ptr = ring_advance(rd_ptr);
                  hdr = hdr | ring_copy[rd_ptr];
                  rd_ptr = ring_advance(rd_ptr);
                  rd_left = hdr;
                  rd_len  = hdr;
                  if (hdr == 0) begin
                     free_left += 2;
                     r.status = STS_EMPTY;
                  end
               end
            end
            if (r.status == STS_OK) begin
               r.data_out = ring_copy[rd_ptr];
               rd_ptr = ring_advance(rd_ptr);
               rd_left--;
               if (rd_left == 0) begin
                  r.last_byte = 1'b1;
                  free_left += rd_len + 2;
               end
            end
         end
         default: ;
      endcase
      r.read_length    = rd_len[LEN_W-1:0];
      r.data_available = (rd_left != 0 || rd_ptr != commit_ptr);
      r.free_bytes     = free_left[SIZE_W-1:0];
      return r;
   endfunction

   function automatic void check_field(string what, int unsigned expected, int unsigned actual);
      if (expected != actual) begin
         mismatches++;
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, expected, actual);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (ring_copy[i])
            ring_copy[i] = '0;
         ring_size = RING_BYTES;
         empty_queue();
         replies_due.delete();
      end else begin
         if (rsp_strobe) begin
            if (replies_due.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result: expected none, actual status %0d data %0d",
                        $time, rsp_status, rsp_data_out);
            end else begin
               want = replies_due.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("data_out", want.data_out, rsp_data_out);
               check_field("last_byte", want.last_byte, rsp_last_byte);
               check_field("read_length", want.read_length, rsp_read_length);
               check_field("data_available", want.data_available, rsp_data_available);
               check_field("free_bytes", want.free_bytes, rsp_free_bytes);
               checked++;
               if (want.last_byte)
                  drained++;
            end
         end
         if (start && !busy)
            replies_due.push_back(apply_item(req_action, req_message_length, req_data_in));
         if (psel && penable && pready && paddr[APB_AW-1:2] == ADDR_BUFFER_SIZE) begin
            if (pwrite)
               apply_size_write(pwdata);
            else
               check_field("buffer_size readback", ring_size, prdata);
         end
      end
      pending = replies_due.size();
   end

endmodule

// ----- tb/length_prefixed_message_fifo_core_test.sv -----
`timescale 1ns / 100ps

module length_prefixed_message_fifo_core_test;
   import lpmf_pkg::*;

   // Action code that the block treats as a no-op.
   localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
   localparam logic [APB_AW-1:0] SIZE_ADDR = {ADDR_BUFFER_SIZE, 2'b00};
   localparam logic [APB_AW-1:0] SPARE_ADDR = 3'b100;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [ACT_W-1:0]    req_action;
   logic [LEN_W-1:0]    req_message_length;
   logic [BYTE_W-1:0]   req_data_in;
   logic                rsp_strobe;
   logic [STAT_W-1:0]   rsp_status;
   logic [BYTE_W-1:0]   rsp_data_out;
   logic                rsp_last_byte;
   logic [LEN_W-1:0]    rsp_read_length;
   logic                rsp_data_available;
   logic [SIZE_W-1:0]   rsp_free_bytes;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [APB_AW-1:0]   paddr;
   logic [APB_DW-1:0]   pwdata;
   logic [APB_DW-1:0]   prdata;
   logic                pready;

   int fail_count;
   int replies_pending;
   int results_checked;
   int messages_drained;

   // Rough view of the queue, kept only to steer the stimulus toward legal message flows.
   int unsigned gen_free;
   int unsigned gen_open;
   int unsigned gen_cur_len;
   int unsigned gen_rd_left;
   int unsigned gen_rd_len;
   int unsigned gen_ready [$];

   int items_sent = 0;
   int size_writes = 0;

   length_prefixed_message_fifo_core dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_action         (req_action),
      .req_message_length (req_message_length),
      .req_data_in        (req_data_in),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_data_out       (rsp_data_out),
      .rsp_last_byte      (rsp_last_byte),
      .rsp_read_length    (rsp_read_length),
      .rsp_data_available (rsp_data_available),
      .rsp_free_bytes     (rsp_free_bytes),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   length_prefixed_message_fifo_core_checker checker_i (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_action         (req_action),
      .req_message_length (req_message_length),
      .req_data_in        (req_data_in),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_data_out       (rsp_data_out),
      .rsp_last_byte      (rsp_last_byte),
      .rsp_read_length    (rsp_read_length),
      .rsp_data_available (rsp_data_available),
      .rsp_free_bytes     (rsp_free_bytes),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready),
      .fail_count         (fail_count),
      .replies_pending    (replies_pending),
      .results_checked    (results_checked),
      .messages_drained   (messages_drained)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("length_prefixed_message_fifo_core_test: FAIL");
      $finish;
   end

   function automatic void clear_gen(int unsigned sz);
      gen_free    = sz;
      gen_open    = 0;
      gen_cur_len = 0;
      gen_rd_left = 0;
      gen_rd_len  = 0;
      gen_ready.delete();
   endfunction

   function automatic void track_item(logic [ACT_W-1:0] act, logic [LEN_W-1:0] len);
      case (act)
         ACT_START: begin
            if (gen_open == 0 && len != 0 && int'(len) + 3 <= gen_free) begin
               gen_free   -= int'(len) + 2;
               gen_open    = len;
               gen_cur_len = len;
            end
         end
         ACT_DATA: begin
            if (gen_open != 0) begin
               gen_open--;
               if (gen_open == 0)
                  gen_ready.push_back(gen_cur_len);
            end
         end
         ACT_READ: begin
            if (gen_rd_left == 0 && gen_ready.size() != 0) begin
               gen_rd_len  = gen_ready.pop_front();
               gen_rd_left = gen_rd_len;
            end
            if (gen_rd_left != 0) begin
               gen_rd_left--;
               if (gen_rd_left == 0)
                  gen_free += gen_rd_len + 2;
            end
         end
         default: ;
      endcase
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_item(logic [ACT_W-1:0] act, logic [LEN_W-1:0] len,
                            logic [BYTE_W-1:0] din);
      start              <= 1'b1;
      req_action         <= act;
      req_message_length <= len;
      req_data_in        <= din;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      items_sent++;
      track_item(act, len);
      @(negedge clock);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      @(negedge clock);
      while (replies_pending != 0)
         @(negedge clock);
   endtask

   task automatic maybe_gap();
      if ($urandom_range(99) < 29) begin
         start <= 1'b0;
         repeat ($urandom_range(6, 1))
            @(negedge clock);
      end
   endtask

   task automatic apb_access(logic wr, logic [APB_AW-1:0] addr, logic [APB_DW-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= addr;
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // The queue must be quiet before the size register is touched.
   task automatic set_buffer_size(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] value);
      logic [SIZE_W-1:0] sz;
      drain_results();
      repeat (6)
         @(negedge clock);
      apb_access(1'b1, addr, value);
      @(negedge clock);
      apb_access(1'b0, addr, '0);
      size_writes++;
      sz = value[SIZE_W-1:0];
      if (addr[APB_AW-1:2] == ADDR_BUFFER_SIZE && sz >= SIZE_MIN)
         clear_gen((sz > RING_BYTES) ? RING_BYTES : sz);
   endtask

   function automatic logic [LEN_W-1:0] pick_length(int unsigned cap);
      int unsigned r;
      r = $urandom_range(99);
      if (r < 8)
         return LEN_W'($urandom_range(16'hFFFF));
      if (r < 14)
         return (gen_free >= 2) ? LEN_W'(gen_free - 2) : '0;
      if (r < 22 && gen_free >= 4 && gen_free - 3 <= cap)
         return LEN_W'(gen_free - 3);
      if (r < 25)
         return '0;
      return LEN_W'($urandom_range(cap, 1));
   endfunction

   task automatic random_item(int unsigned cap);
      int unsigned         r;
      logic [LEN_W-1:0]    len;
      logic [BYTE_W-1:0]   din;
      logic [ACT_W-1:0]    act;
      r   = $urandom_range(99);
      len = LEN_W'($urandom_range(16'hFFFF));
      din = BYTE_W'($urandom_range(255));
      if (gen_open != 0) begin
         if (r < 70)
            act = ACT_DATA;
         else if (r < 88)
            act = ACT_READ;
         else if (r < 95)
            act = ACT_START;
         else
            act = ACT_UNUSED;
      end else begin
         if (r < 45)
            act = ACT_START;
         else if (r < ((gen_ready.size() != 0 || gen_rd_left != 0) ? 87 : 60))
            act = ACT_READ;
         else if (r < 94)
            act = ACT_DATA;
         else
            act = ACT_UNUSED;
      end
      if (act == ACT_START)
         len = pick_length(cap);
      send_item(act, len, din);
   endtask

   task automatic run_phase(int unsigned count, int unsigned cap, bit calm);
      for (int i = 0; i < count; i++) begin
         random_item(cap);
         if (!calm)
            maybe_gap();
         if ($urandom_range(149) == 0)
            drain_results();
      end
   endtask

   initial begin
      reset              = 1'b1;
      start              = 1'b0;
      req_action         = ACT_READ;
      req_message_length = '0;
      req_data_in        = '0;
      psel               = 1'b0;
      penable            = 1'b0;
      pwrite             = 1'b0;
      paddr              = '0;
      pwdata             = '0;
      clear_gen(RING_BYTES);
      repeat (11)
         @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Error paths, length limits and two messages read back across their header fetches.
      send_item(ACT_READ, 16'h0000, 8'h00);
      send_item(ACT_DATA, 16'h0000, 8'hFF);
      send_item(ACT_UNUSED, 16'hFFFF, 8'hFF);
      send_item(ACT_START, 16'h0000, 8'h00);
      send_item(ACT_START, 16'hFFFF, 8'h00);
      send_item(ACT_START, 16'd1022, 8'h00);
      send_item(ACT_START, 16'd3, 8'h00);
      send_item(ACT_START, 16'd5, 8'h00);
      send_item(ACT_READ, 16'h0000, 8'h00);
      send_item(ACT_DATA, 16'h0000, 8'h00);
      send_item(ACT_DATA, 16'h0000, 8'hFF);
      send_item(ACT_DATA, 16'h0000, 8'h5A);
      send_item(ACT_START, 16'd1, 8'h00);
      send_item(ACT_READ, 16'h0000, 8'h00);
      send_item(ACT_READ, 16'h0000, 8'h00);
      send_item(ACT_READ, 16'h0000, 8'h00);
      send_item(ACT_READ, 16'h0000, 8'h00);
      send_item(ACT_DATA, 16'h0000, 8'h81);
      send_item(ACT_READ, 16'hFFFF, 8'hFF);
      send_item(ACT_READ, 16'h0000, 8'h00);

      set_buffer_size(SIZE_ADDR, 32'd16);
      run_phase(280, 13, 1'b0);
      set_buffer_size(SIZE_ADDR, 32'd3);
      run_phase(50, 4, 1'b0);
      set_buffer_size(SIZE_ADDR, 32'd4);
      run_phase(90, 2, 1'b0);
      set_buffer_size(SIZE_ADDR, 32'd5);
      run_phase(90, 3, 1'b0);
      set_buffer_size(SIZE_ADDR, 32'h7FF | ($urandom() & 32'hFFFF_F800));
      run_phase(300, 60, 1'b1);
      // Below the minimum and at an unused address: the queue keeps its contents.
      set_buffer_size(SIZE_ADDR, 32'd1);
      run_phase(150, 60, 1'b0);
      set_buffer_size(SPARE_ADDR, 32'd7);
      run_phase(100, 40, 1'b0);
      set_buffer_size(SIZE_ADDR, 32'h0000_0809);
      run_phase(200, 6, 1'b0);
      set_buffer_size(SIZE_ADDR, 32'd40);
      run_phase(300, 30, 1'b0);
      set_buffer_size(SIZE_ADDR, 32'd1024);
      run_phase(150, 120, 1'b0);
      set_buffer_size(SIZE_ADDR, 32'd200);
      run_phase(240, 20, 1'b0);

      drain_results();
      repeat (8)
         @(posedge clock);
      $display("Sent %0d items over %0d size register writes; %0d results checked.",
               items_sent, size_writes, results_checked);
      $display("%0d complete messages were read back through the ring.", messages_drained);
      if (fail_count == 0 && replies_pending == 0)
         $display("length_prefixed_message_fifo_core_test: PASS");
      else
         $display("length_prefixed_message_fifo_core_test: FAIL");
      $finish;
   end

endmodule

// ----- length_prefixed_message_fifo_core.f -----
+incdir+design
design/lpmf_pkg.sv
design/lpmf_ram.sv
design/lpmf_ctrl.sv
design/lpmf_dp.sv
design/length_prefixed_message_fifo_core.sv
tb/length_prefixed_message_fifo_core_checker.sv
tb/length_prefixed_message_fifo_core_test.sv
